// ===== sv/shm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shm_pkg
// Shared types, constants and helpers for the 64-bit string hash mixer.
// ----------------------------------------------------------------------------
package shm_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int COUNT_W = 4;
  localparam int BYTES   = WORD_W / 8;

  localparam logic [WORD_W-1:0] MIX_C1   = 64'h87c37b91114253d5;
  localparam logic [WORD_W-1:0] MIX_C2   = 64'h4cf5ad432745937f;
  localparam logic [WORD_W-1:0] MIX_ADD  = 64'h0000000052dce729;
  localparam logic [WORD_W-1:0] FIN_C1   = 64'hff51afd7ed558ccd;
  localparam logic [WORD_W-1:0] FIN_C2   = 64'hc4ceb9fe1a85ec53;
  localparam logic [WORD_W-1:0] HASH_TAG = 64'h8000000000000000;

  localparam int ROT_WORD = 31;
  localparam int ROT_HASH = 27;
  localparam int FIN_SHR  = 33;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_H5,
    ST_HADD,
    ST_FSEED,
    ST_EMIT
  } state_t;

  // which 64x64 multiply is in flight; selects the constant and the post-op
  typedef enum logic [1:0] {
    STG_MIX1,
    STG_MIX2,
    STG_FIN1,
    STG_FIN2
  } stage_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_H5,
    OP_HADD,
    OP_FSEED,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t    op;
    stage_t stage;
  } cmd_t;

  typedef struct packed {
    logic mix;   // word on the input is to be mixed into the hash
  } status_t;

  function automatic logic [WORD_W-1:0] stage_const(input stage_t s);
    logic [WORD_W-1:0] k;
    unique case (s)
      STG_MIX1: k = MIX_C1;
      STG_MIX2: k = MIX_C2;
      STG_FIN1: k = FIN_C1;
      STG_FIN2: k = FIN_C2;
      default:  k = MIX_C1;
    endcase
    return k;
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
    return (x << r) | (x >> (WORD_W - r));
  endfunction

endpackage

// ===== sv/shm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shm_in_if / shm_out_if
// Valid/ready channels for string words in and finished hashes out.
// ----------------------------------------------------------------------------
interface shm_in_if;
  logic                         valid;
  logic                         ready;
  logic [shm_pkg::WORD_W-1:0]  data_word;
  logic [shm_pkg::COUNT_W-1:0] byte_count;
  logic                         last;

  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface shm_out_if;
  logic                        valid;
  logic                        ready;
  logic [shm_pkg::WORD_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// ===== sv/shm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shm_ctrl
// Sequencer: steps the datapath through word mixing and finalization.
// ----------------------------------------------------------------------------
module shm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  shm_pkg::status_t  status,
  output shm_pkg::cmd_t     cmd
);

  shm_pkg::state_t state_r, state_nxt;
  shm_pkg::stage_t stage_r, stage_nxt;
  logic            last_r, last_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    last_nxt  = last_r;
    unique case (state_r)
      shm_pkg::ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          if (status.mix) begin
            state_nxt = shm_pkg::ST_MUL0;
            stage_nxt = shm_pkg::STG_MIX1;
          end else if (in_last) begin
            state_nxt = shm_pkg::ST_FSEED;
          end
        end
      end
      shm_pkg::ST_MUL0: state_nxt = shm_pkg::ST_MUL1;
      shm_pkg::ST_MUL1: state_nxt = shm_pkg::ST_MUL2;
      shm_pkg::ST_MUL2: state_nxt = shm_pkg::ST_MUL3;
      shm_pkg::ST_MUL3: begin
        unique case (stage_r)
          shm_pkg::STG_MIX1: begin
            state_nxt = shm_pkg::ST_MUL0;
            stage_nxt = shm_pkg::STG_MIX2;
          end
          shm_pkg::STG_MIX2: state_nxt = shm_pkg::ST_H5;
          shm_pkg::STG_FIN1: begin
            state_nxt = shm_pkg::ST_MUL0;
            stage_nxt = shm_pkg::STG_FIN2;
          end
          shm_pkg::STG_FIN2: state_nxt = shm_pkg::ST_EMIT;
          default:           state_nxt = shm_pkg::ST_IDLE;
        endcase
      end
      shm_pkg::ST_H5:   state_nxt = shm_pkg::ST_HADD;
      shm_pkg::ST_HADD: state_nxt = last_r ? shm_pkg::ST_FSEED : shm_pkg::ST_IDLE;
      shm_pkg::ST_FSEED: begin
        state_nxt = shm_pkg::ST_MUL0;
        stage_nxt = shm_pkg::STG_FIN1;
      end
      shm_pkg::ST_EMIT: begin
        if (out_free) state_nxt = shm_pkg::ST_IDLE;
      end
      default: state_nxt = shm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op        = shm_pkg::OP_NONE;
    cmd.stage     = stage_r;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      shm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = shm_pkg::OP_LOAD;
      end
      shm_pkg::ST_MUL0:  cmd.op = shm_pkg::OP_MUL0;
      shm_pkg::ST_MUL1:  cmd.op = shm_pkg::OP_MUL1;
      shm_pkg::ST_MUL2:  cmd.op = shm_pkg::OP_MUL2;
      shm_pkg::ST_MUL3:  cmd.op = shm_pkg::OP_MUL3;
      shm_pkg::ST_H5:    cmd.op = shm_pkg::OP_H5;
      shm_pkg::ST_HADD:  cmd.op = shm_pkg::OP_HADD;
      shm_pkg::ST_FSEED: cmd.op = shm_pkg::OP_FSEED;
      shm_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.op        = shm_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = shm_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shm_pkg::ST_IDLE;
      stage_r     <= shm_pkg::STG_MIX1;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/shm_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shm_dpath
// Word masking, shared 32x32 multiplier, hash recurrence and output register.
// ----------------------------------------------------------------------------
module shm_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  shm_pkg::cmd_t                cmd,
  input  logic [shm_pkg::WORD_W-1:0]  data_word,
  input  logic [shm_pkg::COUNT_W-1:0] byte_count,
  output shm_pkg::status_t             status,
  output logic [shm_pkg::WORD_W-1:0]  hash_value
);

  localparam int W = shm_pkg::WORD_W;
  localparam int H = shm_pkg::HALF_W;
  localparam int COUNT_W = shm_pkg::COUNT_W;

  logic [W-1:0] x_r, x_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] prod_r, prod_nxt;
  logic [W-1:0] hash_r, hash_nxt;
  logic [W-1:0] out_r, out_nxt;

  logic [W-1:0] masked;
  logic [W-1:0] k;
  logic [H-1:0] mul_a, mul_b;
  logic [W-1:0] mul_sum;
  logic [W-1:0] post;

  // clear bytes at and above byte_count; counts of 8 and up keep all
  always_comb begin
    for (int i = 0; i < shm_pkg::BYTES; i++) begin
      masked[i*8 +: 8] = (byte_count[3] || (byte_count < COUNT_W'(i + 1)) == 1'b0)
                         ? data_word[i*8 +: 8] : 8'h00;
    end
  end

  assign status.mix = byte_count[3] || (|masked);

  assign k = shm_pkg::stage_const(cmd.stage);

  // low 64 bits of x * k from three 32x32 partial products
  always_comb begin
    case (cmd.op)
      shm_pkg::OP_MUL1: begin
        mul_a = x_r[W-1:H];
        mul_b = k[H-1:0];
      end
      shm_pkg::OP_MUL2: begin
        mul_a = x_r[H-1:0];
        mul_b = k[W-1:H];
      end
      default: begin
        mul_a = x_r[H-1:0];
        mul_b = k[H-1:0];
      end
    endcase
  end

  assign prod_nxt = {{H{1'b0}}, mul_a} * {{H{1'b0}}, mul_b};
  assign mul_sum  = acc_r + {prod_r[H-1:0], {H{1'b0}}};

  always_comb begin
    case (cmd.stage)
      shm_pkg::STG_MIX1: post = shm_pkg::rotl(mul_sum, shm_pkg::ROT_WORD);
      shm_pkg::STG_MIX2: post = shm_pkg::rotl(hash_r ^ mul_sum, shm_pkg::ROT_HASH);
      default:           post = mul_sum ^ (mul_sum >> shm_pkg::FIN_SHR);
    endcase
  end

  always_comb begin
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    hash_nxt = hash_r;
    out_nxt  = out_r;
    unique case (cmd.op)
      shm_pkg::OP_NONE:  ;
      shm_pkg::OP_LOAD:  x_nxt = masked;
      shm_pkg::OP_MUL0:  ;
      shm_pkg::OP_MUL1:  acc_nxt = prod_r;
      shm_pkg::OP_MUL2:  acc_nxt = mul_sum;
      shm_pkg::OP_MUL3:  x_nxt = post;
      shm_pkg::OP_H5:    acc_nxt = x_r + {x_r[W-3:0], 2'b00};
      shm_pkg::OP_HADD:  hash_nxt = acc_r + shm_pkg::MIX_ADD;
      shm_pkg::OP_FSEED: begin
        x_nxt    = hash_r ^ (hash_r >> shm_pkg::FIN_SHR);
        hash_nxt = '0;
      end
      shm_pkg::OP_EMIT:  out_nxt = x_r | shm_pkg::HASH_TAG;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  assign hash_value = out_r;

endmodule

// ===== sv/string_hash64_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash64_mixer
// 64-bit string hash over little-endian words, MurmurHash3-style mixing.
// ----------------------------------------------------------------------------
// Takes one string word at a time. A word that is not mixed (count of zero, or
// a partial word that masks to zero) and is not last is only accepted. A mixed
// word is accepted, then runs two 64x64 multiplies, each stepped through states
// MUL0 to MUL3 on the single shared 32x32 multiplier, then the hash times-five
// and offset. A last word then seeds the finalizer, runs two more multiplies and
// loads the output register once it is free. The finished hash sits in an
// output register, so the next string is taken while it waits to be read.
module string_hash64_mixer (
  input logic         clk,
  input logic         rst_n,
  shm_in_if.sink      in_if,
  shm_out_if.source   out_if
);

  shm_pkg::cmd_t    cmd;
  shm_pkg::status_t status;

  shm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.last),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  shm_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .data_word  (in_if.data_word),
    .byte_count (in_if.byte_count),
    .status     (status),
    .hash_value (out_if.hash_value)
  );

endmodule

// ===== test/string_hash64_mixer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash64_mixer_tb
// Streams byte strings as little-endian words into the hash mixer. A local
// model predicts every finished hash, and a monitor compares each one as it
// leaves. Both channels idle at random, the output is held off once for a
// long stretch; in one stretch, each string waits until all hashes are back.
// ----------------------------------------------------------------------------
module string_hash64_mixer_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RAND_WORDS = 550;
  localparam int LONG_HOLD = 400;
  localparam int WORD_W = shm_pkg::WORD_W;
  localparam int COUNT_W = shm_pkg::COUNT_W;

  typedef struct {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] cnt;
    logic               lst;
    bit                 drain;   // wait for every hash before offering this one
  } word_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  shm_in_if  in_ch ();
  shm_out_if out_ch ();

  string_hash64_mixer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #2 clk = ~clk;

  word_item_t        pending_words[$];
  logic [WORD_W-1:0] hash_expected[$];
  logic [WORD_W-1:0] hash_acc;
  int                words_accepted = 0;
  int                hashes_predicted = 0;
  int                results_seen = 0;
  int                total_words = 0;
  int                mismatches = 0;
  int                cycles = 0;
  int                n_counted = 0;
  int                n_strings = 0;
  int                n_odd = 0;
  bit                drain_next = 1'b0;
  logic              calm;

  // no idling in the tail and in one stretch in the middle
  assign calm = (words_accepted >= total_words - 60) ||
                (words_accepted >= 250 && words_accepted < 310);

  function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] x,
                                                 input int r);
    return (x << r) | (x >> (WORD_W - r));
  endfunction

  function automatic logic [WORD_W-1:0] mix_into(input logic [WORD_W-1:0] w,
                                                 input logic [WORD_W-1:0] acc);
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] a;
    k = w * shm_pkg::MIX_C1;
    k = rot_left(k, 31);
    k = k * shm_pkg::MIX_C2;
    a = rot_left(acc ^ k, 27);
    return a * 64'd5 + shm_pkg::MIX_ADD;
  endfunction

  function automatic logic [WORD_W-1:0] finish_hash(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] v;
    v = x ^ (x >> 33);
    v = v * shm_pkg::FIN_C1;
    v = v ^ (v >> 33);
    v = v * shm_pkg::FIN_C2;
    v = v ^ (v >> 33);
    return v | shm_pkg::HASH_TAG;
  endfunction

  task automatic absorb_word(input logic [WORD_W-1:0] w, input logic [COUNT_W-1:0] c,
                             input logic l, output logic emit,
                             output logic [WORD_W-1:0] h);
    logic [WORD_W-1:0] masked;
    emit = 1'b0;
    h = '0;
    if (c >= 4'd8) begin
      hash_acc = mix_into(w, hash_acc);
    end else if (c != 4'd0) begin
      masked = w & ((64'd1 << (8 * c)) - 64'd1);
      if (masked != '0) hash_acc = mix_into(masked, hash_acc);
    end
    if (l) begin
      emit = 1'b1;
      h = finish_hash(hash_acc);
      hash_acc = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("MISMATCH cycle %0d: %s got %h want %h", cycles, what, got, want);
    mismatches++;
  endtask

  function automatic void push_word(input logic [WORD_W-1:0] w,
                                    input logic [COUNT_W-1:0] c, input logic l);
    word_item_t it;
    it.word = w;
    it.cnt = c;
    it.lst = l;
    it.drain = drain_next;
    drain_next = 1'b0;
    pending_words.push_back(it);
    if (c != 4'd0 || l) n_counted++;
    if (l) n_strings++;
    if ((c < 4'd8 && !l && c != 4'd0) || c > 4'd8) n_odd++;
  endfunction

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : driver
    word_item_t        nx;
    logic              emit;
    logic [WORD_W-1:0] h;
    int                pred_now;
    int                gap_left;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
      hash_acc = '0;
    end else begin
      pred_now = hashes_predicted;
      if (in_ch.valid && in_ch.ready) begin
        absorb_word(in_ch.data_word, in_ch.byte_count, in_ch.last, emit, h);
        if (emit) begin
          hash_expected.push_back(h);
          pred_now = pred_now + 1;
        end
        hashes_predicted <= pred_now;
        words_accepted <= words_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() == 0 ||
                     (pending_words[0].drain && pred_now != results_seen)) begin
          in_ch.valid <= 1'b0;
        end else begin
          nx = pending_words.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.data_word <= nx.word;
          in_ch.byte_count <= nx.cnt;
          in_ch.last <= nx.lst;
          if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
        end
      end
    end
  end

  // ------------------------------------------------------------ result ready
  always @(posedge clk) begin : sink_ready
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && words_accepted >= 120) begin
      // long hold-off so the block backs up and stalls its input
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk) begin : monitor
    logic [WORD_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hash_expected.size() == 0) begin
        report_mismatch("hash with none pending", out_ch.hash_value, '0);
      end else begin
        want = hash_expected.pop_front();
        if (out_ch.hash_value !== want)
          report_mismatch("hash_value", out_ch.hash_value, want);
      end
      results_seen <= results_seen + 1;
    end
  end

  // -------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("[string_hash64_mixer] ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------- stimulus + end
  initial begin : stimulus
    logic [WORD_W-1:0] w;
    int                nfull;
    int                c;
    int                kind;
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.byte_count = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;

    // directed strings
    push_word('0, 4'd0, 1'b1);                       // empty string
    push_word('0, 4'd8, 1'b1);                       // full zero word is still mixed
    push_word('1, 4'd8, 1'b1);
    for (int i = 1; i < 8; i++) push_word('1, i[COUNT_W-1:0], 1'b1);
    push_word(rand64(), 4'd9, 1'b1);                 // oversize counts act as 8
    push_word(rand64(), 4'd15, 1'b1);
    push_word(64'hffff_ffff_ff00_0000, 4'd3, 1'b1);  // masks to zero, not mixed
    push_word(rand64(), 4'd3, 1'b0);                 // partial word mid-string
    push_word(rand64(), 4'd8, 1'b0);
    push_word('0, 4'd0, 1'b1);
    push_word('1, 4'd0, 1'b0);                       // count zero, ignored
    push_word(rand64(), 4'd8, 1'b1);
    push_word(rand64(), 4'd8, 1'b0);
    push_word(rand64(), 4'd8, 1'b0);
    push_word(rand64(), 4'd5, 1'b1);
    push_word(rand64(), 4'd12, 1'b0);
    push_word('1, 4'd0, 1'b1);                       // word-aligned finish

    // random strings, mostly well formed, with some odd words mixed in
    while (n_counted < RAND_WORDS + 23) begin
      if (n_counted >= 330 && n_counted < 340) drain_next = 1'b1;
      nfull = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
      for (int i = 0; i < nfull; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          push_word(rand64(), COUNT_W'($urandom_range(9, 15)), 1'b0);
        end else if (kind < 14) begin
          push_word(rand64(), COUNT_W'($urandom_range(1, 7)), 1'b0);
        end else if (kind < 18) begin
          c = $urandom_range(1, 7);
          push_word(rand64() << (8 * c), COUNT_W'(c), 1'b0);
        end else if (kind < 21) begin
          push_word(rand64(), 4'd0, 1'b0);
        end else begin
          push_word(rand64(), 4'd8, 1'b0);
        end
      end
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        push_word(rand64(), COUNT_W'($urandom_range(9, 15)), 1'b1);
      end else if (kind < 20) begin
        c = $urandom_range(1, 7);
        push_word(rand64() << (8 * c), COUNT_W'(c), 1'b1);
      end else begin
        push_word(rand64(), COUNT_W'($urandom_range(0, 8)), 1'b1);
      end
    end
    total_words = pending_words.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_ch.valid) @(posedge clk);
    while (hash_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (hash_expected.size() != 0)
      report_mismatch("hashes still pending", WORD_W'(hash_expected.size()), '0);

    $display("sent %0d words in %0d strings (%0d odd-sized), checked %0d hashes",
             words_accepted, n_strings, n_odd, results_seen);
    $display("included empty strings, masked and oversize counts, a long output hold");
    if (mismatches == 0) begin
      $display("[string_hash64_mixer] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[string_hash64_mixer] ERROR");
    end
    $finish;
  end

endmodule
